FILE: rtl/bdq_pkg.sv
// Shared constants, types and ring arithmetic for the bounded deque.
package bdq_pkg;

   localparam int DEPTH      = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = $clog2(DEPTH);
   localparam int CNT_W      = $clog2(DEPTH + 1);
   localparam int SUM_W      = CNT_W + 1;
   localparam int POS_W      = 8;
   localparam int CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;

   localparam logic [1:0] CMD_PUSH_BACK  = 2'd0;
   localparam logic [1:0] CMD_POP_BACK   = 2'd1;
   localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
   localparam logic [1:0] CMD_READ       = 2'd3;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;
   localparam logic [1:0] ST_RANGE = 2'd3;

   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [DATA_WIDTH-1:0] data_type;

   typedef struct packed {
      logic     wr_en;
      idx_type  wr_addr;
      data_type wr_data;
      logic     rd_en;
      idx_type  rd_addr;
   } ram_req_type;

   // Ring index of the entry that lies off places behind base; off < DEPTH.
   function automatic idx_type ring_slot(idx_type base, cnt_type off);
      logic [SUM_W-1:0] s;
      s = SUM_W'(base) + SUM_W'(off);
      if (s >= SUM_W'(DEPTH)) begin
         s = s - SUM_W'(DEPTH);
      end
      return IDX_W'(s);
   endfunction

endpackage

FILE: rtl/bounded_deque_with_indexed_read.sv
// Bounded double-ended queue held in a ring buffer, with read by position.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    cmd, push_value, position
//   rsp      out        rsp_valid/stall    value, status, entry_count
//
// A command is accepted into the pending stage, together with the registered
// read of the entry store, and its word then moves to the output register on
// rsp; one command per cycle is sustained while rsp is not stalled.
// Reset empties the deque at once; stored words are not cleared.
// While rsp stalls, one further command is held in the pending stage and
// req stalls after that.
module bounded_deque_with_indexed_read (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_push_value,
   input  logic [7:0]  req_position,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_value,
   output logic [1:0]  rsp_status,
   output logic [4:0]  rsp_entry_count
);
   import bdq_pkg::*;

   idx_type     front_ff, front_in;
   cnt_type     count_ff, count_in;
   logic        pend_valid_ff, pend_valid_in;
   logic        pend_use_mem_ff, pend_use_mem_in;
   logic [1:0]  pend_status_ff, pend_status_in;
   cnt_type     pend_count_ff, pend_count_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_value_ff, rsp_value_in;
   logic [1:0]  rsp_status_ff, rsp_status_in;
   cnt_type     rsp_count_ff, rsp_count_in;

   ram_req_type ram_req;
   data_type    rd_data;
   logic        req_accept;
   logic        rsp_load;
   logic        pos_ok;

   bdq_ram u_ram (
      .clock   (clock),
      .ram_req (ram_req),
      .rd_data (rd_data)
   );

   // The pending word moves on when the output register is free or being taken.
   assign rsp_load   = pend_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = pend_valid_ff && !rsp_load;
   assign req_accept = req_valid && !req_stall;
   assign pos_ok     = CMP_W'(req_position) < CMP_W'(count_ff);

   always_comb begin
      front_in        = front_ff;
      count_in        = count_ff;
      pend_use_mem_in = pend_use_mem_ff;
      pend_status_in  = pend_status_ff;
      pend_count_in   = pend_count_ff;
      ram_req.wr_en   = 1'b0;
      ram_req.wr_addr = ring_slot(front_ff, count_ff);
      ram_req.wr_data = req_push_value[DATA_WIDTH-1:0];
      ram_req.rd_en   = 1'b0;
      ram_req.rd_addr = front_ff;
      if (req_accept) begin
         pend_use_mem_in = 1'b0;
         pend_status_in  = ST_OK;
         unique case (req_cmd)
            CMD_PUSH_BACK: begin
               if (count_ff == CNT_W'(DEPTH)) begin
                  pend_status_in = ST_FULL;
               end else begin
                  ram_req.wr_en = 1'b1;
                  count_in      = count_ff + CNT_W'(1);
               end
            end
            CMD_POP_BACK: begin
               if (count_ff == '0) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = ring_slot(front_ff, count_ff - CNT_W'(1));
                  pend_use_mem_in = 1'b1;
                  count_in        = count_ff - CNT_W'(1);
               end
            end
            CMD_POP_FRONT: begin
               if (count_ff == '0) begin
                  pend_status_in = ST_EMPTY;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = front_ff;
                  pend_use_mem_in = 1'b1;
                  front_in        = ring_slot(front_ff, CNT_W'(1));
                  count_in        = count_ff - CNT_W'(1);
               end
            end
            CMD_READ: begin
               if (!pos_ok) begin
                  pend_status_in = ST_RANGE;
               end else begin
                  ram_req.rd_en   = 1'b1;
                  ram_req.rd_addr = ring_slot(front_ff, CNT_W'(req_position));
                  pend_use_mem_in = 1'b1;
               end
            end
            default: begin
               pend_status_in = ST_RANGE;
            end
         endcase
         pend_count_in = count_in;
      end
   end

   always_comb begin
      pend_valid_in = pend_valid_ff;
      if (req_accept) begin
         pend_valid_in = 1'b1;
      end else if (rsp_load) begin
         pend_valid_in = 1'b0;
      end
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = pend_use_mem_ff ? 32'(rd_data) : '0;
         rsp_status_in = pend_status_ff;
         rsp_count_in  = pend_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff      <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         front_ff      <= front_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_use_mem_ff <= pend_use_mem_in;
      pend_status_ff  <= pend_status_in;
      pend_count_ff   <= pend_count_in;
      rsp_value_ff    <= rsp_value_in;
      rsp_status_ff   <= rsp_status_in;
      rsp_count_ff    <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value       = rsp_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = 5'(rsp_count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count beyond depth");

   a_stall_needs_pending: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (pend_valid_ff && rsp_valid_ff))
      else $error("input stalled without a blocked pending word");

   a_accept_fills_pending: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> pend_valid_ff)
      else $error("accepted command left no pending word");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_FULL) |-> (rsp_count_ff == CNT_W'(DEPTH)))
      else $error("full status with a count below depth");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == ST_EMPTY) |-> (rsp_count_ff == '0))
      else $error("empty status with a nonzero count");

endmodule

FILE: rtl/bdq_ram.sv
// Entry store of the deque: one write port and one registered read port.
module bdq_ram (
   input  logic                 clock,
   input  bdq_pkg::ram_req_type ram_req,
   output bdq_pkg::data_type    rd_data
);
   import bdq_pkg::*;

   data_type mem [DEPTH];
   data_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_req.wr_en) begin
         mem[ram_req.wr_addr] <= ram_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ram_req.rd_en) begin
         rd_data_ff <= mem[ram_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: sim/deque_result_checker.sv
// Response checker for the bounded deque: predicts every response word and compares it.
module deque_result_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [31:0] req_push_value,
   input  logic [7:0]  req_position,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [31:0] rsp_value,
   input  logic [1:0]  rsp_status,
   input  logic [4:0]  rsp_entry_count,
   output int          mismatch_count,
   output int          words_pending
);
   import bdq_pkg::*;

   typedef struct {
      data_type   value;
      logic [1:0] status;
      cnt_type    entry_count;
   } outcome_type;

   data_type    slots [DEPTH];
   idx_type     head;
   cnt_type     held;
   outcome_type awaited [$];

   function automatic idx_type slot_at(int off);
      return idx_type'((int'(head) + off) % DEPTH);
   endfunction

   // Applies one command word to the shadow deque and returns the response it should give.
   function automatic outcome_type apply_command(logic [1:0] cmd, data_type word,
                                                 logic [7:0] pos);
      outcome_type res;
      res.value  = '0;
      res.status = ST_OK;
      case (cmd)
         CMD_PUSH_BACK: begin
            if (int'(held) >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               slots[slot_at(int'(held))] = word;
               held = held + CNT_W'(1);
            end
         end
         CMD_POP_BACK: begin
            if (held == '0) begin
               res.status = ST_EMPTY;
            end else begin
               res.value = slots[slot_at(int'(held) - 1)];
               held = held - CNT_W'(1);
            end
         end
         CMD_POP_FRONT: begin
            if (held == '0) begin
               res.status = ST_EMPTY;
            end else begin
               res.value = slots[head];
               head = slot_at(1);
               held = held - CNT_W'(1);
            end
         end
         default: begin
            if (int'(pos) >= int'(held)) begin
               res.status = ST_RANGE;
            end else begin
               res.value = slots[slot_at(int'(pos))];
            end
         end
      endcase
      res.entry_count = held;
      return res;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      if (mismatch_count < 40) begin
         $display("mismatch in %s: got %0h, expected %0h", what, got, want);
      end
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      outcome_type want;
      if (reset) begin
         head = '0;
         held = '0;
         mismatch_count = 0;
         awaited.delete();
      end else begin
         // The request is queued first so that ordering holds whatever the latency.
         if (req_valid && !req_stall) begin
            awaited.push_back(apply_command(req_cmd, req_push_value, req_position));
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited.size() == 0) begin
               report_mismatch("response word with none awaited", rsp_value, '0);
            end else begin
               want = awaited.pop_front();
               if (rsp_value !== want.value) begin
                  report_mismatch("value", rsp_value, 32'(want.value));
               end
               if (rsp_status !== want.status) begin
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               end
               if (rsp_entry_count !== want.entry_count) begin
                  report_mismatch("entry_count", 32'(rsp_entry_count),
                                  32'(want.entry_count));
               end
            end
         end
      end
      words_pending = awaited.size();
   end

endmodule

FILE: sim/testbench.sv
// Top of the deque testbench: clock, reset, command stimulus, response stalls and verdict.
module testbench;
   import bdq_pkg::*;

   localparam int RANDOM_WORDS = 1500;
   localparam int IDLE_LIMIT   = 2000;

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIXED} traffic_mode_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [1:0]  req_cmd;
   logic [31:0] req_push_value;
   logic [7:0]  req_position;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_value;
   logic [1:0]  rsp_status;
   logic [4:0]  rsp_entry_count;
   int          mismatch_count;
   int          words_pending;
   bit          sender_calm;

   bounded_deque_with_indexed_read dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_push_value  (req_push_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   deque_result_checker scoreboard (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_push_value  (req_push_value),
      .req_position    (req_position),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value       (rsp_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count),
      .mismatch_count  (mismatch_count),
      .words_pending   (words_pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Mostly short gaps, now and then a long one, none at all while the sender is calm.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (sender_calm || r < 55) begin
         return 0;
      end else if (r < 92) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // Called at a falling edge; returns at the falling edge after the word is taken, or after a random idle gap.
   task automatic send_command(logic [1:0] cmd, logic [31:0] word, logic [7:0] pos);
      int gap;
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_push_value <= word;
      req_position   <= pos;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   function automatic logic [31:0] pick_word();
      int r;
      r = $urandom_range(0, 99);
      if (r < 4) begin
         return 32'h0000_0000;
      end else if (r < 8) begin
         return 32'hFFFF_FFFF;
      end else if (r < 12) begin
         return 32'h1 << $urandom_range(0, 31);
      end
      return $urandom;
   endfunction

   function automatic logic [7:0] pick_position();
      if ($urandom_range(0, 99) < 85) begin
         return 8'($urandom_range(0, DEPTH));
      end
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [1:0] pick_command(traffic_mode_type mode);
      int r;
      r = $urandom_range(0, 99);
      case (mode)
         MODE_FILL: begin
            if (r < 70) return CMD_PUSH_BACK;
            if (r < 78) return CMD_POP_BACK;
            if (r < 86) return CMD_POP_FRONT;
            return CMD_READ;
         end
         MODE_DRAIN: begin
            if (r < 12) return CMD_PUSH_BACK;
            if (r < 45) return CMD_POP_BACK;
            if (r < 78) return CMD_POP_FRONT;
            return CMD_READ;
         end
         default: begin
            if (r < 30) return CMD_PUSH_BACK;
            if (r < 45) return CMD_POP_BACK;
            if (r < 60) return CMD_POP_FRONT;
            return CMD_READ;
         end
      endcase
   endfunction

   // Response stalls come in runs; long free-flowing stretches appear now and then.
   initial begin
      int run_left;
      int r;
      rsp_stall = 1'b0;
      run_left  = 0;
      forever begin
         @(negedge clock);
         if (run_left > 0) begin
            run_left--;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
               rsp_stall <= 1'b0;
               run_left  = $urandom_range(0, 20);
            end else if (r < 52) begin
               rsp_stall <= 1'b0;
               run_left  = $urandom_range(100, 300);
            end else if (r < 90) begin
               rsp_stall <= 1'b1;
               run_left  = $urandom_range(0, 2);
            end else begin
               rsp_stall <= 1'b1;
               run_left  = $urandom_range(8, 40);
            end
         end
      end
   end

   // Ends the run if neither channel moves a word for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   initial begin
      traffic_mode_type mode;
      int               mode_left;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_PUSH_BACK;
      req_push_value = '0;
      req_position   = '0;
      sender_calm    = 1'b0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part: empty deque, extreme words, reads in and out of range.
      send_command(CMD_POP_BACK,  '0, '0);
      send_command(CMD_POP_FRONT, '0, '0);
      send_command(CMD_READ,      '0, 8'd0);
      send_command(CMD_READ,      '0, 8'hFF);
      send_command(CMD_PUSH_BACK, 32'h0000_0000, 8'hFF);
      send_command(CMD_PUSH_BACK, 32'hFFFF_FFFF, '0);
      send_command(CMD_PUSH_BACK, 32'hA5A5_5A5A, '0);
      send_command(CMD_READ,      '0, 8'd0);
      send_command(CMD_READ,      '0, 8'd2);
      send_command(CMD_READ,      '0, 8'd3);
      send_command(CMD_READ,      '0, 8'hFF);
      send_command(CMD_POP_BACK,  '0, '0);
      send_command(CMD_POP_FRONT, '0, '0);
      send_command(CMD_POP_FRONT, '0, '0);
      send_command(CMD_POP_BACK,  '0, '0);

      // Random part: the first stretch fills the deque so that refused pushes occur early.
      mode      = MODE_FILL;
      mode_left = 60;
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (mode_left == 0) begin
            mode        = traffic_mode_type'($urandom_range(0, 2));
            mode_left   = $urandom_range(10, 60);
            sender_calm = ($urandom_range(0, 99) < 20);
         end
         mode_left--;
         if (n == RANDOM_WORDS / 2) begin
            // Hold off until every outstanding response word has been returned.
            req_valid <= 1'b0;
            while (words_pending != 0) @(negedge clock);
         end
         send_command(pick_command(mode), pick_word(), pick_position());
      end

      req_valid <= 1'b0;
      while (words_pending != 0) @(negedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && words_pending == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
